/* sv/csev_pkg.sv */
// ----------------------------------------------------------------------------
// csev_pkg: shared definitions for the cubic spline evaluator
// Widths, codes, sequencer states and the control bundle of the Horner unit.
// ----------------------------------------------------------------------------
package csev_pkg;

  localparam int VAL_W         = 32;
  localparam int DX_W          = VAL_W + 1;
  localparam int PROD_W        = DX_W + VAL_W;
  localparam int FRAC_W        = 16;
  localparam int CNT_CFG_W     = 7;
  localparam int IDX_OUT_W     = 6;
  localparam int COEF_W        = 4 * VAL_W;
  localparam int MAX_KNOTS_DEF = 64;

  localparam logic [CNT_CFG_W-1:0] KNOT_COUNT_RST = CNT_CFG_W'(3);

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EVAL = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DX,
    ST_MUL,
    ST_ADD
  } state_t;

  typedef enum logic [1:0] {
    SEL_C,
    SEL_B,
    SEL_Y
  } coef_sel_t;

  typedef struct packed {
    logic      mul_en;
    coef_sel_t coef_sel;
  } mac_ctrl_t;

endpackage

/* sv/cubic_spline_evaluator.sv */
// ----------------------------------------------------------------------------
// cubic_spline_evaluator: Q16.16 cubic spline evaluation over a knot table
// A load transaction writes one knot. An evaluate transaction occupies the
// block until its result is registered: a binary search probes the knot
// table, each probe a registered read of the abscissa RAM, then dx is formed,
// and the single shared multiplier runs the three Horner steps (multiply,
// then round, add and saturate). The next transaction is taken while a
// result still waits on the output.
// ----------------------------------------------------------------------------
module cubic_spline_evaluator #(
  parameter int MAX_KNOTS = csev_pkg::MAX_KNOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_action,
  input  logic [5:0]                            in_knot_index,
  input  logic signed [csev_pkg::VAL_W-1:0]     in_knot_x,
  input  logic signed [csev_pkg::VAL_W-1:0]     in_knot_y,
  input  logic signed [csev_pkg::VAL_W-1:0]     in_coef_b,
  input  logic signed [csev_pkg::VAL_W-1:0]     in_coef_c,
  input  logic signed [csev_pkg::VAL_W-1:0]     in_coef_d,
  input  logic signed [csev_pkg::VAL_W-1:0]     in_arg_u,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [csev_pkg::VAL_W-1:0]     out_spline_value,
  output logic [csev_pkg::IDX_OUT_W-1:0]        out_interval_index,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [csev_pkg::CNT_CFG_W-1:0]        cfg_knot_count
);

  localparam int IDX_W = $clog2(MAX_KNOTS);
  localparam int CNT_W = $clog2(MAX_KNOTS + 1);
  localparam int CMP_W = (CNT_W > csev_pkg::CNT_CFG_W) ? CNT_W : csev_pkg::CNT_CFG_W;
  localparam int VW    = csev_pkg::VAL_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_KNOTS);

  csev_pkg::state_t    state_r, state_nxt;
  csev_pkg::coef_sel_t stage_r, stage_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt, hi_r, hi_nxt, k_r, k_nxt;
  logic signed [VW-1:0] u_r, u_nxt, t_r, t_nxt;
  logic signed [csev_pkg::DX_W-1:0] dx_r, dx_nxt;
  logic [csev_pkg::CNT_CFG_W-1:0] knot_count_r, knot_count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic signed [VW-1:0] out_value_r, out_value_nxt;
  logic [csev_pkg::IDX_OUT_W-1:0] out_index_r, out_index_nxt;

  logic                in_accept;
  logic                load_ok;
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [VW-1:0]       x_rdata;
  logic [csev_pkg::COEF_W-1:0] coef_rdata;
  logic [CNT_W-1:0]    n_eff, lo_s, hi_s, mid;
  logic [CNT_W:0]      mid_sum;
  logic                x_lt, more;
  csev_pkg::mac_ctrl_t mac_ctrl;
  logic signed [VW-1:0] mac_sum;

  assign in_stall  = (state_r != csev_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign load_ok   = CMP_W'(in_knot_index) < MAX_CMP;
  assign ram_we    = in_accept && (in_action == csev_pkg::ACT_LOAD) && load_ok;
  assign ram_waddr = IDX_W'(in_knot_index);
  assign n_eff     = (CMP_W'(knot_count_r) > MAX_CMP) ? CNT_W'(MAX_KNOTS)
                                                      : CNT_W'(knot_count_r);

  csev_ram #(.WIDTH(VW), .DEPTH(MAX_KNOTS)) u_x_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_knot_x),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (x_rdata)
  );

  csev_ram #(.WIDTH(csev_pkg::COEF_W), .DEPTH(MAX_KNOTS)) u_coef_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_knot_y, in_coef_b, in_coef_c, in_coef_d}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (coef_rdata)
  );

  csev_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .dx     (dx_r),
    .t      (t_r),
    .coef_y (coef_rdata[4*VW-1:3*VW]),
    .coef_b (coef_rdata[3*VW-1:2*VW]),
    .coef_c (coef_rdata[2*VW-1:VW]),
    .sum    (mac_sum)
  );

  always_comb begin
    x_lt = u_r < $signed(x_rdata);
    if (state_r == csev_pkg::ST_SEARCH) begin
      lo_s = x_lt ? lo_r : k_r;
      hi_s = x_lt ? k_r : hi_r;
    end else begin
      lo_s = '0;
      hi_s = n_eff;
    end
    mid_sum   = {1'b0, lo_s} + {1'b0, hi_s};
    mid       = mid_sum[CNT_W:1];
    more      = {1'b0, hi_s} > ({1'b0, lo_s} + (CNT_W + 1)'(1));
    ram_raddr = more ? IDX_W'(mid) : IDX_W'(lo_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= csev_pkg::ST_IDLE;
      stage_r      <= csev_pkg::SEL_C;
      out_valid_r  <= 1'b0;
      knot_count_r <= csev_pkg::KNOT_COUNT_RST;
    end else begin
      state_r      <= state_nxt;
      stage_r      <= stage_nxt;
      out_valid_r  <= out_valid_nxt;
      knot_count_r <= knot_count_nxt;
    end
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    k_r         <= k_nxt;
    u_r         <= u_nxt;
    dx_r        <= dx_nxt;
    t_r         <= t_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    stage_nxt       = stage_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    k_nxt           = k_r;
    u_nxt           = u_r;
    dx_nxt          = dx_r;
    t_nxt           = t_r;
    out_value_nxt   = out_value_r;
    out_index_nxt   = out_index_r;
    out_valid_nxt   = out_valid_r && out_stall;
    knot_count_nxt  = (cfg_valid && cfg_ready) ? cfg_knot_count : knot_count_r;
    ram_re          = 1'b0;
    mac_ctrl.mul_en   = 1'b0;
    mac_ctrl.coef_sel = stage_r;
    unique case (state_r)
      csev_pkg::ST_IDLE: begin
        if (in_accept && (in_action == csev_pkg::ACT_EVAL)) begin
          ram_re    = 1'b1;
          u_nxt     = in_arg_u;
          lo_nxt    = lo_s;
          hi_nxt    = hi_s;
          k_nxt     = mid;
          state_nxt = more ? csev_pkg::ST_SEARCH : csev_pkg::ST_DX;
        end
      end
      csev_pkg::ST_SEARCH: begin
        ram_re = 1'b1;
        lo_nxt = lo_s;
        hi_nxt = hi_s;
        k_nxt  = mid;
        if (!more) begin
          state_nxt = csev_pkg::ST_DX;
        end
      end
      csev_pkg::ST_DX: begin
        dx_nxt    = {u_r[VW-1], u_r} - {x_rdata[VW-1], x_rdata};
        t_nxt     = coef_rdata[VW-1:0];
        stage_nxt = csev_pkg::SEL_C;
        state_nxt = csev_pkg::ST_MUL;
      end
      csev_pkg::ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = csev_pkg::ST_ADD;
      end
      csev_pkg::ST_ADD: begin
        unique case (stage_r)
          csev_pkg::SEL_C: begin
            t_nxt     = mac_sum;
            stage_nxt = csev_pkg::SEL_B;
            state_nxt = csev_pkg::ST_MUL;
          end
          csev_pkg::SEL_B: begin
            t_nxt     = mac_sum;
            stage_nxt = csev_pkg::SEL_Y;
            state_nxt = csev_pkg::ST_MUL;
          end
          csev_pkg::SEL_Y: begin
            if (!out_valid_r || !out_stall) begin
              out_value_nxt = mac_sum;
              out_index_nxt = csev_pkg::IDX_OUT_W'(lo_r);
              out_valid_nxt = 1'b1;
              state_nxt     = csev_pkg::ST_IDLE;
            end
          end
          default: state_nxt = csev_pkg::ST_IDLE;
        endcase
      end
      default: state_nxt = csev_pkg::ST_IDLE;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_spline_value   = out_value_r;
  assign out_interval_index = out_index_r;

`ifndef SYNTHESIS
  a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csev_pkg::ST_SEARCH) |-> (lo_r < k_r) && (k_r < hi_r))
    else $error("search probe lies outside its interval");

  a_search_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csev_pkg::ST_SEARCH) |-> (CMP_W'(hi_r) <= MAX_CMP))
    else $error("search bound exceeds the table depth");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_action == csev_pkg::ACT_EVAL)) |=> in_stall)
    else $error("evaluate transaction did not occupy the block");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |->
      $past((state_r == csev_pkg::ST_ADD) && (stage_r == csev_pkg::SEL_Y)))
    else $error("result appeared without a final Horner step");
`endif

endmodule

/* sv/csev_ram.sv */
// ----------------------------------------------------------------------------
// csev_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module csev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/csev_mac.sv */
// ----------------------------------------------------------------------------
// csev_mac: shared Horner multiply-add unit
// Registers dx*t, then rounds to Q16.16, adds the selected coefficient and
// saturates to 32 bits.
// ----------------------------------------------------------------------------
module csev_mac (
  input  logic                                clk,
  input  csev_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [csev_pkg::DX_W-1:0]    dx,
  input  logic signed [csev_pkg::VAL_W-1:0]   t,
  input  logic signed [csev_pkg::VAL_W-1:0]   coef_y,
  input  logic signed [csev_pkg::VAL_W-1:0]   coef_b,
  input  logic signed [csev_pkg::VAL_W-1:0]   coef_c,
  output logic signed [csev_pkg::VAL_W-1:0]   sum
);

  localparam int Q_W   = csev_pkg::PROD_W - csev_pkg::FRAC_W;
  localparam int SUM_W = Q_W + 1;
  localparam int VW    = csev_pkg::VAL_W;

  logic signed [csev_pkg::PROD_W-1:0] prod_r;
  logic signed [csev_pkg::PROD_W-1:0] prod_nxt;
  logic signed [csev_pkg::PROD_W-1:0] rounded;
  logic signed [Q_W-1:0]              q;
  logic signed [VW-1:0]               coef;
  logic signed [SUM_W-1:0]            wide_sum;
  logic                               in_range;

  assign prod_nxt = ctrl.mul_en ? dx * t : prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_comb begin
    unique case (ctrl.coef_sel)
      csev_pkg::SEL_C: coef = coef_c;
      csev_pkg::SEL_B: coef = coef_b;
      csev_pkg::SEL_Y: coef = coef_y;
      default:         coef = coef_y;
    endcase
  end

  assign rounded  = prod_r + csev_pkg::PROD_W'(1 << (csev_pkg::FRAC_W - 1));
  assign q        = rounded[csev_pkg::PROD_W-1:csev_pkg::FRAC_W];
  assign wide_sum = SUM_W'(q) + SUM_W'(coef);
  assign in_range = (&wide_sum[SUM_W-1:VW-1]) || !(|wide_sum[SUM_W-1:VW-1]);

  always_comb begin
    if (in_range) begin
      sum = wide_sum[VW-1:0];
    end else if (wide_sum[SUM_W-1]) begin
      sum = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sum = {1'b0, {(VW-1){1'b1}}};
    end
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the cubic spline evaluator
// Loads knot sets through the input channel, evaluates the spline at directed
// and random arguments, predicts each result in the bench and compares it
// field by field, under random idling on both channels and knot_count changes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csev_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam logic signed [VAL_W-1:0] Q_MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN32 = 32'sh8000_0000;
  localparam longint SAT_HI = 64'sh7FFF_FFFF;
  localparam longint SAT_LO = -64'sh8000_0000;

  typedef struct {
    action_t                 action;
    logic [5:0]              knot_index;
    logic signed [VAL_W-1:0] knot_x;
    logic signed [VAL_W-1:0] knot_y;
    logic signed [VAL_W-1:0] coef_b;
    logic signed [VAL_W-1:0] coef_c;
    logic signed [VAL_W-1:0] coef_d;
    logic signed [VAL_W-1:0] arg_u;
  } spline_txn_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [IDX_OUT_W-1:0]    interval;
  } spline_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_action = 1'b0;
  logic [5:0]                    in_knot_index = '0;
  logic signed [VAL_W-1:0]       in_knot_x = '0;
  logic signed [VAL_W-1:0]       in_knot_y = '0;
  logic signed [VAL_W-1:0]       in_coef_b = '0;
  logic signed [VAL_W-1:0]       in_coef_c = '0;
  logic signed [VAL_W-1:0]       in_coef_d = '0;
  logic signed [VAL_W-1:0]       in_arg_u = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [VAL_W-1:0]       out_spline_value;
  logic [IDX_OUT_W-1:0]          out_interval_index;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CNT_CFG_W-1:0]          cfg_knot_count = KNOT_COUNT_RST;

  logic signed [VAL_W-1:0] knot_x_tab [MAX_KNOTS_DEF];
  logic signed [VAL_W-1:0] ord_tab    [MAX_KNOTS_DEF];
  logic signed [VAL_W-1:0] lin_tab    [MAX_KNOTS_DEF];
  logic signed [VAL_W-1:0] quad_tab   [MAX_KNOTS_DEF];
  logic signed [VAL_W-1:0] cubic_tab  [MAX_KNOTS_DEF];
  logic [CNT_CFG_W-1:0]    knot_limit = KNOT_COUNT_RST;
  spline_result_t          pending_results [$];
  spline_result_t          head_result;
  int                      set_size = 3;
  int                      mismatch_count = 0;
  int                      cycle_count = 0;
  int                      send_gap_pct = 0;
  int                      recv_stall_pct = 0;
  int                      hold_cycles = 0;
  int                      stall_burst = 0;

  cubic_spline_evaluator DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_knot_index      (in_knot_index),
    .in_knot_x          (in_knot_x),
    .in_knot_y          (in_knot_y),
    .in_coef_b          (in_coef_b),
    .in_coef_c          (in_coef_c),
    .in_coef_d          (in_coef_d),
    .in_arg_u           (in_arg_u),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_spline_value   (out_spline_value),
    .out_interval_index (out_interval_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_knot_count     (cfg_knot_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall <= 1'b1;
    end else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
      stall_burst = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result, expected none, actual value %h index %0d",
                 $time, out_spline_value, out_interval_index);
      end else begin
        head_result = pending_results.pop_front();
        if (out_spline_value !== head_result.value) begin
          mismatch_count++;
          $display("%0t ns: spline_value mismatch, expected %h, actual %h",
                   $time, head_result.value, out_spline_value);
        end
        if (out_interval_index !== head_result.interval) begin
          mismatch_count++;
          $display("%0t ns: interval_index mismatch, expected %0d, actual %0d",
                   $time, head_result.interval, out_interval_index);
        end
      end
    end
  end

  function automatic longint horner_step(logic signed [VAL_W-1:0] coef, longint dx,
                                         longint t);
    longint s;
    s = longint'(coef) + ((dx * t + 32768) >>> FRAC_W);
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return s;
  endfunction

  function automatic spline_result_t eval_spline(logic signed [VAL_W-1:0] u);
    spline_result_t r;
    int n;
    int lo;
    int hi;
    int mid;
    longint dx;
    longint acc;
    n = (knot_limit > MAX_KNOTS_DEF) ? MAX_KNOTS_DEF : int'(knot_limit);
    lo = 0;
    hi = n;
    while (hi > lo + 1) begin
      mid = (lo + hi) / 2;
      if (u < knot_x_tab[mid]) begin
        hi = mid;
      end else begin
        lo = mid;
      end
    end
    dx = longint'(u) - longint'(knot_x_tab[lo]);
    acc = longint'(cubic_tab[lo]);
    acc = horner_step(quad_tab[lo], dx, acc);
    acc = horner_step(lin_tab[lo], dx, acc);
    acc = horner_step(ord_tab[lo], dx, acc);
    r.value = acc[VAL_W-1:0];
    r.interval = lo[IDX_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp_q16(longint v);
    if (v > SAT_HI) begin
      return Q_MAX32;
    end else if (v < SAT_LO) begin
      return Q_MIN32;
    end
    return v[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      6, 7: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      8: return $urandom();
      default: return $urandom_range(0, 1) ? Q_MAX32 : Q_MIN32;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_arg();
    int k;
    longint base;
    k = $urandom_range(0, set_size - 1);
    base = longint'(knot_x_tab[k]);
    case ($urandom_range(0, 9))
      0, 1: return knot_x_tab[k];
      2, 3, 4: return clamp_q16(base + longint'($urandom_range(0, 32'h0002_0000)));
      5: return clamp_q16(base - longint'($urandom_range(1, 32'h0000_4000)));
      6: return clamp_q16(longint'(knot_x_tab[0]) -
                          longint'($urandom_range(1, 32'h0010_0000)));
      7: return clamp_q16(longint'(knot_x_tab[set_size-1]) +
                          longint'($urandom_range(0, 32'h0010_0000)));
      8: return $urandom();
      default: return $urandom_range(0, 1) ? Q_MAX32 : Q_MIN32;
    endcase
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  // Offers one transaction, waits for its acceptance and updates the prediction.
  // Valid is left high so that a following transaction can go out back to back.
  task automatic send_txn(spline_txn_t t);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= t.action;
    in_knot_index <= t.knot_index;
    in_knot_x     <= t.knot_x;
    in_knot_y     <= t.knot_y;
    in_coef_b     <= t.coef_b;
    in_coef_c     <= t.coef_c;
    in_coef_d     <= t.coef_d;
    in_arg_u      <= t.arg_u;
    do @(posedge clk); while (in_stall);
    if (t.action == ACT_LOAD) begin
      knot_x_tab[t.knot_index] = t.knot_x;
      ord_tab[t.knot_index]    = t.knot_y;
      lin_tab[t.knot_index]    = t.coef_b;
      quad_tab[t.knot_index]   = t.coef_c;
      cubic_tab[t.knot_index]  = t.coef_d;
    end else begin
      pending_results.push_back(eval_spline(t.arg_u));
    end
  endtask

  task automatic load_knot(int idx, logic signed [VAL_W-1:0] x, logic signed [VAL_W-1:0] y,
                           logic signed [VAL_W-1:0] b, logic signed [VAL_W-1:0] c,
                           logic signed [VAL_W-1:0] d);
    spline_txn_t t;
    t.action     = ACT_LOAD;
    t.knot_index = 6'(idx);
    t.knot_x     = x;
    t.knot_y     = y;
    t.coef_b     = b;
    t.coef_c     = c;
    t.coef_d     = d;
    t.arg_u      = $urandom();
    send_txn(t);
  endtask

  task automatic evaluate(logic signed [VAL_W-1:0] u);
    spline_txn_t t;
    t.action     = ACT_EVAL;
    t.knot_index = 6'($urandom());
    t.knot_x     = $urandom();
    t.knot_y     = $urandom();
    t.coef_b     = $urandom();
    t.coef_c     = $urandom();
    t.coef_d     = $urandom();
    t.arg_u      = u;
    send_txn(t);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_knot_count(int count);
    drain_results();
    cfg_knot_count <= CNT_CFG_W'(count);
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    knot_limit = CNT_CFG_W'(count);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_knot_set(int n, bit sorted, bit wide);
    longint maxstep;
    longint slack;
    longint pos;
    maxstep = wide ? longint'(64'hFFFF_FFFF / n) : longint'($urandom_range(1, 32'h0002_0000));
    slack = 64'hFFFF_FFFF - n * maxstep;
    pos = SAT_LO;
    if ($urandom_range(0, 3) != 0) begin
      pos = pos + longint'($urandom_range(0, slack[31:0]));
    end
    for (int i = 0; i < n; i++) begin
      if (sorted) begin
        load_knot(i, pos[VAL_W-1:0], rand_coef(), rand_coef(), rand_coef(), rand_coef());
        pos = pos + longint'($urandom_range(1, maxstep[31:0]));
      end else begin
        load_knot(i, $urandom(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
      end
    end
    set_size = n;
  endtask

  task automatic run_knot_phase(int count, int n, bit sorted, bit wide, int evals);
    set_knot_count(count);
    load_knot_set(n, sorted, wide);
    repeat (evals) begin
      if ($urandom_range(0, 9) == 0) begin
        load_knot($urandom_range(0, 63), $urandom(), rand_coef(), rand_coef(), rand_coef(),
                  rand_coef());
      end else begin
        evaluate(pick_arg());
      end
    end
  endtask

  task automatic test_directed_knots();
    load_knot(0, Q_MIN32, Q_MAX32, Q_MAX32, Q_MAX32, Q_MAX32);
    load_knot(1, 0, Q_MIN32, Q_MIN32, Q_MIN32, Q_MIN32);
    load_knot(2, Q_MAX32, 32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000, -32'sh0000_2000);
    set_size = 3;
    evaluate(Q_MIN32);
    evaluate(Q_MIN32 + 32'sh0001_8000);
    evaluate(-32'sh0000_0001);
    evaluate(0);
    evaluate(32'sh7FFF_0000);
    evaluate(Q_MAX32);
    load_knot(0, -32'sh0001_0000, 0, 32'sh0001_0000, 0, 0);
    load_knot(1, 0, 32'sh0000_8000, 0, 32'sh0000_8000, 0);
    load_knot(2, 32'sh0001_0000, 0, -32'sh0000_8000, 0, 0);
    evaluate(-32'sh0002_0000);
    evaluate(-32'sh0000_0001);
    evaluate(32'sh0000_0001);
    evaluate(32'sh0001_0001);
    evaluate(32'sh0001_0000);
    evaluate(Q_MIN32);
  endtask

  task automatic test_ascending_sets();
    int n;
    repeat (10) begin
      send_gap_pct   = pick_idle_pct();
      recv_stall_pct = pick_idle_pct();
      n = $urandom_range(3, 16);
      run_knot_phase(n, n, 1'b1, $urandom_range(0, 1), 30);
    end
  endtask

  task automatic test_full_table();
    send_gap_pct   = 10;
    recv_stall_pct = 10;
    run_knot_phase(MAX_KNOTS_DEF, MAX_KNOTS_DEF, 1'b1, 1'b1, 30);
    run_knot_phase(127, MAX_KNOTS_DEF, 1'b1, 1'b0, 30);
  endtask

  task automatic test_short_counts();
    for (int c = 0; c < 3; c++) begin
      set_knot_count(c);
      repeat (10) evaluate(pick_arg());
    end
  endtask

  task automatic test_unsorted_knots();
    int n;
    n = $urandom_range(3, 12);
    run_knot_phase(n, n, 1'b0, 1'b0, 30);
  endtask

  task automatic test_output_hold();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_cycles    = 400;
    repeat (30) evaluate(pick_arg());
  endtask

  task automatic test_sender_pause();
    send_gap_pct   = 20;
    recv_stall_pct = 20;
    repeat (15) evaluate(pick_arg());
    drain_results();
    repeat (15) evaluate(pick_arg());
  endtask

  task automatic test_final_stream();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_knot_phase(8, 8, 1'b1, 1'b0, 60);
  endtask

  initial begin
    for (int i = 0; i < MAX_KNOTS_DEF; i++) begin
      knot_x_tab[i] = '0;
      ord_tab[i]    = '0;
      lin_tab[i]    = '0;
      quad_tab[i]   = '0;
      cubic_tab[i]  = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_gap_pct   = 30;
    recv_stall_pct = 30;
    test_directed_knots();
    test_ascending_sets();
    test_full_table();
    test_short_counts();
    test_unsorted_knots();
    test_output_hold();
    test_sender_pause();
    test_final_stream();
    drain_results();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
